// ===== rtl/vector_tile_geometry_encoder_assert.svh =====
// Assertion macros shared by the vector tile geometry encoder RTL.
`ifndef VECTOR_TILE_GEOMETRY_ENCODER_ASSERT_SVH
`define VECTOR_TILE_GEOMETRY_ENCODER_ASSERT_SVH

// When the antecedent holds, the consequent must hold in the same cycle.
`define VTGE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define VTGE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/vtge_pkg.sv =====
// Package with types, constants and helper functions of the geometry encoder.
`default_nettype none
package vtge_pkg;

    localparam int unsigned CoordWidth = 32;
    localparam int unsigned CountWidth = 29;
    localparam int unsigned WordWidth  = 32;
    localparam int unsigned MaxWords   = 4;
    localparam int unsigned WordIdxW   = $clog2(MaxWords);

    localparam logic [2:0] CmdMoveTo    = 3'd1;
    localparam logic [2:0] CmdLineTo    = 3'd2;
    localparam logic [2:0] CmdClosePath = 3'd7;

    typedef enum logic [1:0] {
        KIND_POINT      = 2'd0,
        KIND_MULTIPOINT = 2'd1,
        KIND_LINESTRING = 2'd2,
        KIND_RING       = 2'd3
    } t_geom_kind;

    typedef struct packed {
        logic [CoordWidth-1:0] x_coord;
        logic [CoordWidth-1:0] y_coord;
        t_geom_kind            geom_kind;
        logic                  first_in_geometry;
        logic                  first_in_part;
        logic                  last_in_part;
        logic [CountWidth-1:0] part_count;
    } t_vertex;

    // All words one vertex produces; last_idx is the index of its final word.
    typedef struct packed {
        logic [MaxWords-1:0][WordWidth-1:0] words;
        logic [WordIdxW-1:0]                last_idx;
    } t_word_bundle;

    function automatic logic [WordWidth-1:0] cmd_word(input logic [2:0] id,
                                                      input logic [CountWidth-1:0] cnt);
        cmd_word = {cnt, id};
    endfunction

    function automatic logic [WordWidth-1:0] zigzag(input logic [WordWidth-1:0] v);
        zigzag = {v[WordWidth-2:0], 1'b0} ^ {WordWidth{v[WordWidth-1]}};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/vtge_encode.sv =====
// Cursor register and the word builder for one vertex.
`default_nettype none
module vtge_encode
    import vtge_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_vertex      i_vertex,
    input  wire logic         i_load,
    output t_word_bundle      o_bundle
);

    logic [CoordWidth-1:0] r_cur_x, r_cur_y;
    logic [CoordWidth-1:0] n_cur_x, n_cur_y;
    logic [CoordWidth-1:0] base_x, base_y;
    logic [WordWidth-1:0]  zz_x, zz_y;
    logic [CountWidth-1:0] line_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= '0;
            r_cur_y <= '0;
        end else begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
        end
    end

    // The cursor follows every vertex, a ring's closing vertex included.
    assign n_cur_x = i_load ? i_vertex.x_coord : r_cur_x;
    assign n_cur_y = i_load ? i_vertex.y_coord : r_cur_y;

    assign base_x = i_vertex.first_in_geometry ? '0 : r_cur_x;
    assign base_y = i_vertex.first_in_geometry ? '0 : r_cur_y;
    assign zz_x   = zigzag(i_vertex.x_coord - base_x);
    assign zz_y   = zigzag(i_vertex.y_coord - base_y);

    // A short count wraps within the 29 count bits of the command word.
    assign line_cnt = (i_vertex.geom_kind == KIND_RING)
                    ? i_vertex.part_count - CountWidth'(2)
                    : i_vertex.part_count - CountWidth'(1);

    always_comb begin
        o_bundle          = '0;
        o_bundle.words[1] = zz_x;
        o_bundle.words[2] = zz_y;
        if (i_vertex.geom_kind == KIND_POINT) begin
            o_bundle.words[0] = cmd_word(CmdMoveTo, CountWidth'(1));
            o_bundle.last_idx = WordIdxW'(2);
        end else if (i_vertex.first_in_part) begin
            o_bundle.words[0] = (i_vertex.geom_kind == KIND_MULTIPOINT)
                              ? cmd_word(CmdMoveTo, i_vertex.part_count)
                              : cmd_word(CmdMoveTo, CountWidth'(1));
            o_bundle.words[3] = cmd_word(CmdLineTo, line_cnt);
            o_bundle.last_idx = (i_vertex.geom_kind == KIND_MULTIPOINT)
                              ? WordIdxW'(2) : WordIdxW'(3);
        end else if (i_vertex.geom_kind == KIND_RING && i_vertex.last_in_part) begin
            o_bundle.words[0] = cmd_word(CmdClosePath, CountWidth'(1));
            o_bundle.last_idx = WordIdxW'(0);
        end else begin
            o_bundle.words[0] = zz_x;
            o_bundle.words[1] = zz_y;
            o_bundle.last_idx = WordIdxW'(1);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/vtge_out_buf.sv =====
// Result register that holds one vertex's words and sends them one per cycle while m_axis_tready is high.
`default_nettype none
module vtge_out_buf
    import vtge_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_word_bundle         i_bundle,
    input  wire logic                 i_load,
    output logic                      o_free,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [WordWidth-1:0]      m_axis_tdata,   // [31:0] word
    output logic                      m_axis_tlast    // last_word
);

    t_word_bundle        r_bundle;
    logic                r_valid, n_valid;
    logic [WordIdxW-1:0] r_idx, n_idx;
    logic                take;

    assign take          = r_valid && m_axis_tready;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_bundle.words[r_idx];
    assign m_axis_tlast  = (r_idx == r_bundle.last_idx);
    // Free when empty, or once the final word of the held vertex leaves in this cycle.
    assign o_free        = !r_valid || (take && m_axis_tlast);

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (i_load) begin
            n_valid = 1'b1;
            n_idx   = '0;
        end else if (take) begin
            n_valid = !m_axis_tlast;
            n_idx   = r_idx + WordIdxW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bundle <= i_bundle;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/vector_tile_geometry_encoder.sv =====
// Top level: vertex input register, word builder and word output buffer.
// A vertex's first word is presented after it passes the input register and is loaded into the output buffer.
// Throughput: one output word per cycle while m_axis_tready is high; a vertex gives one to four
// words (two for an ordinary vertex, up to four at a part start).
// Reset (synchronous, active low) empties both stages and clears the cursor to 0,0.
`default_nettype none
`include "vector_tile_geometry_encoder_assert.svh"
module vector_tile_geometry_encoder
    import vtge_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,  // [31:0] x_coord, [63:32] y_coord, [92:64] part_count
    input  wire logic [3:0]  s_axis_tuser,  // [1:0] geom_kind, [2] first_in_geometry, [3] first_in_part
    input  wire logic        s_axis_tlast,  // last_in_part
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // [31:0] word
    output logic             m_axis_tlast   // last_word
);

    t_vertex      r_vertex;
    logic         r_in_valid, n_in_valid;
    logic         in_take, load, out_free;
    t_word_bundle bundle;

    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign load          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || load;
    assign n_in_valid    = in_take || (r_in_valid && !load);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_vertex.x_coord           <= s_axis_tdata[31:0];
            r_vertex.y_coord           <= s_axis_tdata[63:32];
            r_vertex.part_count        <= s_axis_tdata[92:64];
            r_vertex.geom_kind         <= t_geom_kind'(s_axis_tuser[1:0]);
            r_vertex.first_in_geometry <= s_axis_tuser[2];
            r_vertex.first_in_part     <= s_axis_tuser[3];
            r_vertex.last_in_part      <= s_axis_tlast;
        end
    end

    vtge_encode u_encode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vertex (r_vertex),
        .i_load   (load),
        .o_bundle (bundle)
    );

    vtge_out_buf u_out_buf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_bundle      (bundle),
        .i_load        (load),
        .o_free        (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    `VTGE_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, load && m_axis_tvalid, m_axis_tready && m_axis_tlast, "words of a vertex overwritten before delivery")
    `VTGE_ASSERT_NEXT(a_held_vertex_kept, i_clk, i_rst_n, r_in_valid && !load, r_in_valid && $stable(r_vertex), "held vertex lost or changed while waiting")
    `VTGE_ASSERT_NEXT(a_load_gives_word, i_clk, i_rst_n, load, m_axis_tvalid, "loaded vertex produced no output transaction")

endmodule
`default_nettype wire

// ===== sim/vector_tile_geometry_encoder_test.sv =====
// Self-checking testbench for the vector tile geometry encoder: vertex streams in, words checked.
module vector_tile_geometry_encoder_test;
    import vtge_pkg::*;

    localparam int RandomItems = 150;
    localparam int CycleLimit  = 200000;
    localparam int DrainCycles = 8;

    typedef struct packed {
        logic [31:0] word;
        logic        last_word;
    } t_geom_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;  // [31:0] x_coord, [63:32] y_coord, [92:64] part_count
    logic [3:0]  s_axis_tuser = '0;  // [1:0] geom_kind, [2] first_in_geometry, [3] first_in_part
    logic        s_axis_tlast = 1'b0;  // last_in_part
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;  // [31:0] word
    logic        m_axis_tlast;  // last_word

    t_vertex    pending_vertices[$];
    t_geom_word expected_words[$];
    logic [31:0] pen_x = '0;
    logic [31:0] pen_y = '0;
    logic [31:0] gen_x, gen_y;
    int mismatches = 0;
    int cycle_count = 0;
    int send_idle = 0;
    int recv_stall = 0;
    int random_items;
    logic       send_valid;
    t_vertex    accepted_vertex;
    t_geom_word got_word, want_word;

    vector_tile_geometry_encoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [31:0] cmd_of(input logic [2:0] id, input logic [28:0] cnt);
        cmd_of = (32'(cnt) << 3) | 32'(id);
    endfunction

    function automatic logic [31:0] zz_code(input logic [31:0] d);
        zz_code = (d << 1) ^ (d[31] ? 32'hFFFF_FFFF : 32'h0);
    endfunction

    // Expected words of one accepted vertex; the pen follows every vertex, closing ones too.
    function automatic void encode_vertex(input t_vertex v);
        logic [31:0] dx, dy;
        logic [31:0] words[4];
        int n;
        t_geom_word w;
        n = 0;
        if (v.first_in_geometry) begin
            pen_x = '0;
            pen_y = '0;
        end
        dx = v.x_coord - pen_x;
        dy = v.y_coord - pen_y;
        pen_x = v.x_coord;
        pen_y = v.y_coord;
        if (v.geom_kind == KIND_POINT) begin
            words[0] = cmd_of(CmdMoveTo, 29'd1);
            words[1] = zz_code(dx);
            words[2] = zz_code(dy);
            n = 3;
        end else if (v.first_in_part) begin
            words[0] = (v.geom_kind == KIND_MULTIPOINT) ? cmd_of(CmdMoveTo, v.part_count)
                                                         : cmd_of(CmdMoveTo, 29'd1);
            words[1] = zz_code(dx);
            words[2] = zz_code(dy);
            n = 3;
            if (v.geom_kind == KIND_LINESTRING) begin
                words[3] = cmd_of(CmdLineTo, v.part_count - 29'd1);
                n = 4;
            end else if (v.geom_kind == KIND_RING) begin
                words[3] = cmd_of(CmdLineTo, v.part_count - 29'd2);
                n = 4;
            end
        end else if (v.geom_kind == KIND_RING && v.last_in_part) begin
            words[0] = cmd_of(CmdClosePath, 29'd1);
            n = 1;
        end else begin
            words[0] = zz_code(dx);
            words[1] = zz_code(dy);
            n = 2;
        end
        for (int k = 0; k < n; k++) begin
            w.word = words[k];
            w.last_word = (k == n - 1);
            expected_words = {expected_words, w};
        end
    endfunction

    function automatic void add_vertex(input logic [31:0] x, input logic [31:0] y,
                                       input t_geom_kind kind, input logic fg,
                                       input logic fp, input logic lp,
                                       input logic [28:0] cnt);
        t_vertex v;
        v.x_coord = x;
        v.y_coord = y;
        v.geom_kind = kind;
        v.first_in_geometry = fg;
        v.first_in_part = fp;
        v.last_in_part = lp;
        v.part_count = cnt;
        pending_vertices = {pending_vertices, v};
    endfunction

    // Half of the picks are short moves from the previous vertex, the rest anywhere or at the range ends.
    function automatic logic [31:0] pick_coord(input logic [31:0] base);
        case ($urandom_range(0, 3))
            0, 1: pick_coord = base + $urandom_range(0, 200) - 32'd100;
            2: pick_coord = $urandom;
            default: begin
                case ($urandom_range(0, 3))
                    0: pick_coord = 32'h7FFF_FFFF;
                    1: pick_coord = 32'h8000_0000;
                    2: pick_coord = 32'hFFFF_FFFF;
                    default: pick_coord = 32'h0;
                endcase
            end
        endcase
    endfunction

    // One well-formed geometry with random content; returns the number of vertices queued.
    function automatic int add_random_geometry();
        t_geom_kind kind;
        int parts, n, total;
        logic [28:0] cnt;
        logic [31:0] x, y, x0, y0;
        logic fg, fp, lp;
        kind = t_geom_kind'($urandom_range(0, 3));
        parts = (kind == KIND_POINT) ? 1 : $urandom_range(1, 3);
        total = 0;
        gen_x = '0;
        gen_y = '0;
        for (int p = 0; p < parts; p++) begin
            case (kind)
                KIND_POINT:      n = 1;
                KIND_MULTIPOINT: n = $urandom_range(1, 5);
                KIND_LINESTRING: n = $urandom_range(2, 5);
                default:         n = $urandom_range(4, 6);
            endcase
            cnt = 29'(n);
            if ($urandom_range(0, 9) == 0)
                cnt = 29'($urandom);
            for (int i = 0; i < n; i++) begin
                if (kind == KIND_RING && i == n - 1) begin
                    x = x0;
                    y = y0;
                end else begin
                    x = pick_coord(gen_x);
                    y = pick_coord(gen_y);
                end
                if (i == 0) begin
                    x0 = x;
                    y0 = y;
                end
                fg = (p == 0 && i == 0);
                fp = (i == 0);
                lp = (i == n - 1);
                if (kind == KIND_POINT) begin
                    fg = ($urandom_range(0, 3) != 0);
                    fp = 1'($urandom_range(0, 1));
                    lp = 1'($urandom_range(0, 1));
                end
                add_vertex(x, y, kind, fg, fp, lp, (i == 0) ? cnt : 29'($urandom));
                gen_x = x;
                gen_y = y;
                total++;
            end
        end
        return total;
    endfunction

    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if ((cycle_count % 600) < 120 || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Vertex driver: holds an item until its transaction, then idles for a random gap.
    always @(posedge i_clk) begin
        send_valid = s_axis_tvalid;
        if (s_axis_tvalid && s_axis_tready) begin
            accepted_vertex = pending_vertices.pop_front();
            encode_vertex(accepted_vertex);
            send_valid = 1'b0;
            send_idle = next_gap();
        end
        if (!send_valid && i_rst_n) begin
            if (send_idle > 0) begin
                send_idle--;
            end else if (pending_vertices.size() > 0) begin
                s_axis_tdata <= {3'b000, pending_vertices[0].part_count,
                                 pending_vertices[0].y_coord, pending_vertices[0].x_coord};
                s_axis_tuser <= {pending_vertices[0].first_in_part,
                                 pending_vertices[0].first_in_geometry,
                                 pending_vertices[0].geom_kind};
                s_axis_tlast <= pending_vertices[0].last_in_part;
                send_valid = 1'b1;
            end
        end
        s_axis_tvalid <= send_valid;
    end

    // Word monitor with random back-pressure.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            got_word.word = m_axis_tdata;
            got_word.last_word = m_axis_tlast;
            if (expected_words.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word, expected none, actual word %h last %b",
                         $time, got_word.word, got_word.last_word);
            end else begin
                want_word = expected_words.pop_front();
                if (got_word.word !== want_word.word) begin
                    mismatches++;
                    $display("%0t: word mismatch, expected %h, actual %h",
                             $time, want_word.word, got_word.word);
                end
                if (got_word.last_word !== want_word.last_word) begin
                    mismatches++;
                    $display("%0t: last_word mismatch, expected %b, actual %b",
                             $time, want_word.last_word, got_word.last_word);
                end
            end
        end
        if (recv_stall > 0) begin
            recv_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 99) < 30)
                recv_stall = next_gap();
        end
    end

    initial begin
        // Points at the coordinate extremes, with part flags and count that must be ignored.
        add_vertex(32'h7FFF_FFFF, 32'h8000_0000, KIND_POINT, 1'b1, 1'b1, 1'b1, 29'h1FFF_FFFF);
        add_vertex(32'h8000_0000, 32'h7FFF_FFFF, KIND_POINT, 1'b0, 1'b0, 1'b0, 29'h0);
        add_vertex(32'hFFFF_FFFF, 32'h0, KIND_POINT, 1'b1, 1'b0, 1'b1, 29'h0AAA_AAAA);
        // Multipoint: count on the first vertex only.
        add_vertex(32'd10, 32'd20, KIND_MULTIPOINT, 1'b1, 1'b1, 1'b0, 29'd3);
        add_vertex(32'd5, 32'hFFFF_FFF0, KIND_MULTIPOINT, 1'b0, 1'b0, 1'b0, 29'h1FFF_FFFF);
        add_vertex(32'd7, 32'd7, KIND_MULTIPOINT, 1'b0, 1'b0, 1'b1, 29'h1555_5555);
        add_vertex(32'h8000_0000, 32'hFFFF_FFFF, KIND_MULTIPOINT, 1'b1, 1'b1, 1'b1,
                   29'h1FFF_FFFF);
        // Line strings, including a count of zero, which wraps, and a count of one.
        add_vertex(32'd100, 32'd200, KIND_LINESTRING, 1'b1, 1'b1, 1'b0, 29'd2);
        add_vertex(32'd50, 32'd300, KIND_LINESTRING, 1'b0, 1'b0, 1'b1, 29'd0);
        add_vertex(32'd60, 32'd310, KIND_LINESTRING, 1'b0, 1'b1, 1'b0, 29'd0);
        add_vertex(32'd61, 32'd300, KIND_LINESTRING, 1'b0, 1'b0, 1'b1, 29'd9);
        add_vertex(32'hFFFF_FF00, 32'd1, KIND_LINESTRING, 1'b1, 1'b1, 1'b1, 29'd1);
        // Square ring whose closing vertex still moves the cursor.
        add_vertex(32'd5, 32'd5, KIND_RING, 1'b1, 1'b1, 1'b0, 29'd4);
        add_vertex(32'd15, 32'd5, KIND_RING, 1'b0, 1'b0, 1'b0, 29'd0);
        add_vertex(32'd15, 32'd15, KIND_RING, 1'b0, 1'b0, 1'b0, 29'd0);
        add_vertex(32'd5, 32'd5, KIND_RING, 1'b0, 1'b0, 1'b1, 29'd0);
        // Rings with short counts, and one vertex marked both first and last.
        add_vertex(32'd3, 32'd4, KIND_RING, 1'b0, 1'b1, 1'b0, 29'd0);
        add_vertex(32'd3, 32'd4, KIND_RING, 1'b0, 1'b0, 1'b1, 29'd0);
        add_vertex(32'd9, 32'd9, KIND_RING, 1'b1, 1'b1, 1'b1, 29'd1);
        add_vertex(32'd1, 32'd2, KIND_RING, 1'b0, 1'b1, 1'b0, 29'd2);
        add_vertex(32'd1, 32'd2, KIND_RING, 1'b0, 1'b0, 1'b1, 29'd2);
        // New geometry that starts on a vertex not marked as part start.
        add_vertex(32'd40, 32'd41, KIND_MULTIPOINT, 1'b1, 1'b0, 1'b0, 29'd6);

        random_items = 0;
        while (random_items < RandomItems) begin
            if ($urandom_range(0, 99) < 15) begin
                add_vertex($urandom, $urandom, t_geom_kind'($urandom_range(0, 3)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), 29'($urandom));
                random_items++;
            end else begin
                random_items += add_random_geometry();
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_vertices.size() > 0 || s_axis_tvalid || expected_words.size() > 0)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
